FILE: rtl/core/ohg_pkg.sv
package ohg_pkg;

	localparam int OccWidth  = 9;
	localparam int TimeWidth = 64;
	localparam int CntWidth  = 32;
	localparam int CfgWidth  = 32;
	localparam int RegIdxWidth = 3;

	localparam logic [1:0] CMD_OBSERVE        = 2'd0;
	localparam logic [1:0] CMD_FORCE_OPEN     = 2'd1;
	localparam logic [1:0] CMD_RESTORE_CLOSED = 2'd2;

	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_CLOSED = 2'd1;
	localparam logic [1:0] ACT_OPENED = 2'd2;

	localparam logic [RegIdxWidth-1:0] REG_OPEN_SLOTS    = 3'd0;
	localparam logic [RegIdxWidth-1:0] REG_CLOSE_SLOTS   = 3'd1;
	localparam logic [RegIdxWidth-1:0] REG_MIN_CLOSED_US = 3'd2;
	localparam logic [RegIdxWidth-1:0] REG_MAX_CLOSED_US = 3'd3;
	localparam logic [RegIdxWidth-1:0] REG_MIN_OPEN_US   = 3'd4;

	localparam logic [7:0]          OPEN_SLOTS_RST    = 8'd1;
	localparam logic [OccWidth-1:0] CLOSE_SLOTS_RST   = 9'd3;
	localparam logic [CfgWidth-1:0] MIN_CLOSED_US_RST = 32'd0;
	localparam logic [CfgWidth-1:0] MAX_CLOSED_US_RST = 32'd1000000;
	localparam logic [CfgWidth-1:0] MIN_OPEN_US_RST   = 32'd0;

endpackage

FILE: rtl/core/occupancy_hysteresis_gate_core.sv
// Occupancy-driven flow-control gate with hysteresis and a safety timeout.
// Input channel: in_valid/in_stall carries cmd, occupancy and now_us; a
// transfer happens at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall carries action, gate_open and the
// close, escape and closed-time statistics, one result per input item.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high and indexes beyond the register list are ignored.
// Configuration should only be written while no item is in flight.
// An item is captured in the input register, and the gate decision is made
// from it and stored in the result register. Throughput is one item per
// cycle while the receiver does not stall; the gate state is updated in the
// same cycle as the result, so consecutive items see each other's effect.
// When the receiver stalls, the result register holds and in_stall rises
// only once the input register is also full.
// Reset opens the gate, clears all counters and timestamps, and loads the
// default thresholds; no result is pending after reset.
module occupancy_hysteresis_gate_core
	import ohg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             cmd,
	input  logic [OccWidth-1:0]    occupancy,
	input  logic [TimeWidth-1:0]   now_us,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             action,
	output logic                   gate_open,
	output logic [CntWidth-1:0]    close_count,
	output logic [CntWidth-1:0]    escape_count,
	output logic [TimeWidth-1:0]   closed_time_total,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [RegIdxWidth-1:0] cfg_index,
	input  logic [CfgWidth-1:0]    cfg_data
);

	logic [7:0]          open_slots_q;
	logic [OccWidth-1:0] close_slots_q;
	logic [CfgWidth-1:0] min_closed_q;
	logic [CfgWidth-1:0] max_closed_q;
	logic [CfgWidth-1:0] min_open_q;

	logic                 valid_s1;
	logic [1:0]           cmd_s1;
	logic [OccWidth-1:0]  used_s1;
	logic [TimeWidth-1:0] now_s1;

	logic                 valid_s2;
	logic [1:0]           action_s2;

	logic                 is_open_q;
	logic [TimeWidth-1:0] closed_at_q;
	logic [TimeWidth-1:0] escape_at_q;
	logic [CntWidth-1:0]  closes_q;
	logic [CntWidth-1:0]  escapes_q;
	logic [TimeWidth-1:0] accum_q;

	logic                 advance_s2;
	logic                 proc_s1;
	logic                 load_s1;

	logic [OccWidth-1:0]  eff_close;
	logic [CfgWidth-1:0]  eff_max;
	logic                 after_close;
	logic [TimeWidth-1:0] elapsed;
	logic [TimeWidth-1:0] dwell;
	logic                 dwell_on;

	logic                 open_nx;
	logic [TimeWidth-1:0] closed_at_nx;
	logic [TimeWidth-1:0] escape_at_nx;
	logic [CntWidth-1:0]  closes_nx;
	logic [CntWidth-1:0]  escapes_nx;
	logic [TimeWidth-1:0] accum_nx;
	logic [1:0]           action_nx;

	assign advance_s2 = !valid_s2 || !out_stall;
	assign proc_s1    = valid_s1 && advance_s2;
	assign load_s1    = !valid_s1 || proc_s1;
	assign in_stall   = !load_s1;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_slots_q  <= OPEN_SLOTS_RST;
			close_slots_q <= CLOSE_SLOTS_RST;
			min_closed_q  <= MIN_CLOSED_US_RST;
			max_closed_q  <= MAX_CLOSED_US_RST;
			min_open_q    <= MIN_OPEN_US_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OPEN_SLOTS:    open_slots_q  <= cfg_data[7:0];
				REG_CLOSE_SLOTS:   close_slots_q <= cfg_data[OccWidth-1:0];
				REG_MIN_CLOSED_US: min_closed_q  <= cfg_data;
				REG_MAX_CLOSED_US: max_closed_q  <= cfg_data;
				REG_MIN_OPEN_US:   min_open_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			cmd_s1  <= cmd;
			used_s1 <= occupancy;
			now_s1  <= now_us;
		end
	end

	assign eff_close   = (close_slots_q < ({1'b0, open_slots_q} + 9'd1)) ?
		({1'b0, open_slots_q} + 9'd1) : close_slots_q;
	assign eff_max     = (max_closed_q < min_closed_q) ? min_closed_q : max_closed_q;
	assign after_close = now_s1 > closed_at_q;
	assign elapsed     = after_close ? (now_s1 - closed_at_q) : '0;
	assign dwell       = now_s1 - escape_at_q;
	assign dwell_on    = (escape_at_q != '0) && (now_s1 > escape_at_q) &&
		(dwell < {32'd0, min_open_q});

	always_comb begin
		open_nx      = is_open_q;
		closed_at_nx = closed_at_q;
		escape_at_nx = escape_at_q;
		closes_nx    = closes_q;
		escapes_nx   = escapes_q;
		accum_nx     = accum_q;
		action_nx    = ACT_NONE;
		case (cmd_s1)
			CMD_OBSERVE: begin
				if (is_open_q) begin
					if (used_s1 < eff_close) begin
						escape_at_nx = '0;
					end else if (!dwell_on) begin
						escape_at_nx = '0;
						open_nx      = 1'b0;
						closed_at_nx = now_s1;
						closes_nx    = closes_q + 32'd1;
						action_nx    = ACT_CLOSED;
					end
				end else if (elapsed >= {32'd0, eff_max}) begin
					escapes_nx   = escapes_q + 32'd1;
					accum_nx     = accum_q + elapsed;
					open_nx      = 1'b1;
					closed_at_nx = '0;
					escape_at_nx = (now_s1 != '0) ? now_s1 : 64'd1;
					action_nx    = ACT_OPENED;
				end else if (elapsed >= {32'd0, min_closed_q} &&
						used_s1 <= {1'b0, open_slots_q}) begin
					accum_nx     = accum_q + elapsed;
					open_nx      = 1'b1;
					closed_at_nx = '0;
					action_nx    = ACT_OPENED;
				end
			end
			CMD_FORCE_OPEN: begin
				if (!is_open_q) begin
					accum_nx     = accum_q + elapsed;
					open_nx      = 1'b1;
					closed_at_nx = '0;
				end
			end
			CMD_RESTORE_CLOSED: begin
				if (is_open_q) begin
					open_nx      = 1'b0;
					closed_at_nx = now_s1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_open_q   <= 1'b1;
			closed_at_q <= '0;
			escape_at_q <= '0;
			closes_q    <= '0;
			escapes_q   <= '0;
			accum_q     <= '0;
			valid_s2    <= 1'b0;
		end else begin
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
			if (proc_s1) begin
				is_open_q   <= open_nx;
				closed_at_q <= closed_at_nx;
				escape_at_q <= escape_at_nx;
				closes_q    <= closes_nx;
				escapes_q   <= escapes_nx;
				accum_q     <= accum_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc_s1) begin
			action_s2 <= action_nx;
		end
	end

	assign out_valid         = valid_s2;
	assign action            = action_s2;
	assign gate_open         = is_open_q;
	assign close_count       = closes_q;
	assign escape_count      = escapes_q;
	assign closed_time_total = accum_q;

`ifndef SYNTH
	a_state_only_on_item: assert property (@(posedge clk) disable iff (!arst_n)
		(is_open_q != $past(is_open_q)) |-> $past(proc_s1))
		else $error("gate state changed without an item");
	a_closed_action: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action == ACT_CLOSED) |-> !gate_open)
		else $error("close reported while gate open");
	a_opened_action: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action == ACT_OPENED) |-> gate_open)
		else $error("open reported while gate closed");
	a_close_count: assert property (@(posedge clk) disable iff (!arst_n)
		(closes_q != $past(closes_q)) |-> (valid_s2 && action_s2 == ACT_CLOSED))
		else $error("close count moved without a close");
`endif

endmodule
